### rtl/upd_pkg.sv
// shared types, character constants and hex helper for the uri percent decoder
package upd_pkg;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  // character codes
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  // decode mode bits
  localparam int unsigned MODE_URI_BIT   = 0;
  localparam int unsigned MODE_REDIR_BIT = 1;

  // one queued command: a single result, or a three-byte re-escape
  typedef struct packed {
    logic       has_byte;
    logic [7:0] val;
    logic       stop;
    logic       triple;
    logic [7:0] dig1;
    logic [7:0] dig2;
    logic       last;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;
    logic       stopped_here;
  } res_t;

  // hex digit value, bit 4 set when the byte is no hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] lc;
    logic [7:0] d;
    lc = b | CH_CASE;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      d = b - CH_ZERO;
      hex_val = {1'b0, d[3:0]};
    end else if (lc >= CH_LC_A && lc <= CH_LC_F) begin
      d = lc - CH_LC_A + 8'd10;
      hex_val = {1'b0, d[3:0]};
    end else begin
      hex_val = 5'h10;
    end
  endfunction

endpackage

### rtl/uri_percent_decoder_core.sv
// top level of the uri percent decoder
// Decodes a percent-escaped URI string, one byte per input item, into one to
// three result items per byte. The front takes a new byte every cycle while
// the command queue has room and the back emits one result per cycle while
// out_stall is low, so the sustained rate is one byte per cycle for plain
// bytes and escapes; a re-escaped value in redirect mode gives three results
// and once the queue fills the input stalls while they go out. An accepted
// byte passes the command queue and the output register before its first
// result. A nonzero decode_mode stops decoding at '?' and bit 1 re-escapes
// unsafe decoded values; write it only while the block is idle.
module uri_percent_decoder_core
  import upd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_has_byte,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_last,
  output logic       out_stopped_here
);

  logic q_full, q_push, q_pop, q_head_valid;
  cmd_t q_data, q_head;
  res_t res;

  upd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_is_last  (in_is_last),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign out_has_byte     = res.has_byte;
  assign out_byte         = res.out_byte;
  assign out_run_last     = res.run_last;
  assign out_string_last  = res.string_last;
  assign out_stopped_here = res.stopped_here;

`ifndef SYNTHESIS
  a_stop_is_qmark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped_here |->
      out_has_byte && out_byte == CH_QMARK && out_run_last)
    else $error("stop marker on a result other than a final question mark");
  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_byte == 8'h00 && out_run_last)
    else $error("empty result carries data or is not final");
`endif

endmodule

### rtl/upd_front.sv
// front part: accepts bytes, tracks escape phase and builds commands
module upd_front
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  localparam logic [1:0] PH_PLAIN   = 2'd0;
  localparam logic [1:0] PH_QUOTED  = 2'd1;
  localparam logic [1:0] PH_SECOND  = 2'd2;
  localparam logic [1:0] PH_STOPPED = 2'd3;

  logic [1:0] mode_r;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic [7:0] dig_r, dig_nxt;

  logic [4:0] hv;
  logic [7:0] ch;
  logic       safe;
  logic       is_dec;
  cmd_t       cmd;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = cmd;

  // classify the byte against the current phase
  always_comb begin
    hv        = hex_val(in_byte);
    ch        = {nib_r, hv[3:0]};
    safe      = (ch > CH_PCT) && (ch < CH_DEL);
    is_dec    = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    dig_nxt   = dig_r;
    cmd       = '0;
    cmd.dig1  = dig_r;
    cmd.dig2  = in_byte;
    cmd.last  = in_is_last;
    case (phase_r)
      PH_PLAIN: begin
        if (in_byte == CH_QMARK && mode_r != 2'b00) begin
          cmd.has_byte = 1'b1;
          cmd.val      = in_byte;
          cmd.stop     = 1'b1;
          phase_nxt    = PH_STOPPED;
        end else if (in_byte == CH_PCT) begin
          phase_nxt = PH_QUOTED;
        end else begin
          cmd.has_byte = 1'b1;
          cmd.val      = in_byte;
        end
      end
      PH_QUOTED: begin
        if (!hv[4]) begin
          nib_nxt   = hv[3:0];
          dig_nxt   = in_byte;
          phase_nxt = PH_SECOND;
        end else begin
          phase_nxt    = PH_PLAIN;
          cmd.has_byte = 1'b1;
          cmd.val      = in_byte;
        end
      end
      PH_SECOND: begin
        phase_nxt = PH_PLAIN;
        if (!hv[4]) begin
          if (is_dec) begin
            if (mode_r[MODE_REDIR_BIT] && !safe) begin
              cmd.triple = 1'b1;
            end else begin
              cmd.has_byte = 1'b1;
              cmd.val      = ch;
            end
          end else if (mode_r != 2'b00) begin
            if (ch == CH_QMARK) begin
              cmd.has_byte = 1'b1;
              cmd.val      = ch;
              cmd.stop     = 1'b1;
              phase_nxt    = PH_STOPPED;
            end else if (mode_r[MODE_URI_BIT] || safe) begin
              cmd.has_byte = 1'b1;
              cmd.val      = ch;
            end else begin
              cmd.triple = 1'b1;
            end
          end else begin
            cmd.has_byte = 1'b1;
            cmd.val      = ch;
          end
        end
      end
      default: begin
        // stopped until the end of the string
        phase_nxt = PH_STOPPED;
      end
    endcase
    if (in_is_last) begin
      phase_nxt = PH_PLAIN;
    end
  end

  // mode register and escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 2'b01;
      phase_r <= PH_PLAIN;
      nib_r   <= '0;
      dig_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (q_push) begin
        phase_r <= phase_nxt;
        nib_r   <= nib_nxt;
        dig_r   <= dig_nxt;
      end
    end
  end

endmodule

### rtl/upd_queue.sv
// small command queue between front and back
module upd_queue
  import upd_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic head_valid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

### rtl/upd_back.sv
// back part: expands commands into result items behind an output register
module upd_back
  import upd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cmd_t head,
  input  logic head_valid,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output res_t res
);

  localparam logic [1:0] SEQ_PCT  = 2'd0;
  localparam logic [1:0] SEQ_DIG1 = 2'd1;
  localparam logic [1:0] SEQ_DIG2 = 2'd2;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r;
  res_t       res_r, res_nxt;
  logic       load, fire;

  assign load      = !valid_r || !out_stall;
  assign fire      = load && head_valid;
  assign pop       = fire && (!head.triple || idx_r == SEQ_DIG2);
  assign out_valid = valid_r;
  assign res       = res_r;

  // select the result for the current position in the command
  always_comb begin
    res_nxt = '0;
    idx_nxt = idx_r;
    if (!head.triple) begin
      res_nxt.has_byte     = head.has_byte;
      res_nxt.out_byte     = head.val;
      res_nxt.run_last     = 1'b1;
      res_nxt.string_last  = head.last;
      res_nxt.stopped_here = head.stop;
      idx_nxt              = SEQ_PCT;
    end else begin
      res_nxt.has_byte = 1'b1;
      case (idx_r)
        SEQ_PCT: begin
          res_nxt.out_byte = CH_PCT;
          idx_nxt          = SEQ_DIG1;
        end
        SEQ_DIG1: begin
          res_nxt.out_byte = head.dig1;
          idx_nxt          = SEQ_DIG2;
        end
        default: begin
          res_nxt.out_byte    = head.dig2;
          res_nxt.run_last    = 1'b1;
          res_nxt.string_last = head.last;
          idx_nxt             = SEQ_PCT;
        end
      endcase
    end
  end

  // output register and sequence position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= SEQ_PCT;
    end else if (load) begin
      valid_r <= head_valid;
      if (head_valid) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd3)
    else $error("re-escape position out of range");
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid && res.run_last)
    else $error("command retired without a final result");
`endif

endmodule
